FILE: src/lpfrc_pkg.sv
// Shared types, constants and CRC function for the length-prefixed frame receiver.
package lpfrc_pkg;

  localparam int BYTE_W      = 8;
  localparam int CRC_W       = 16;
  localparam int POS_W       = 9;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CRC_W-1:0] CRC_GENERATOR = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT      = 16'h0000;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_FOLLOW = 1'b1;

  localparam logic RES_DATA    = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  localparam logic [POS_W-1:0] POS_IDLE = 9'd0;
  localparam logic [POS_W-1:0] POS_ADDR = 9'd1;
  localparam logic [POS_W-1:0] POS_LEN  = 9'd2;
  localparam logic [POS_W-1:0] POS_DATA = 9'd3;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic              crc_ok;
    logic [CRC_W-1:0]  received_crc;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] frame_address;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] data_index;
    logic [BYTE_W-1:0] data_byte;
    logic              result_kind;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_GENERATOR;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

FILE: src/lpfrc_in_stage.sv
// Input register stage for received byte requests.
module lpfrc_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  output logic             s_ready,
  input  lpfrc_pkg::item_t s_item,
  input  logic             advance,
  output logic             valid,
  output lpfrc_pkg::item_t item
);
  import lpfrc_pkg::*;

  logic valid_next;

  assign s_ready    = !valid || advance;
  assign valid_next = (s_valid && s_ready) || (valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

FILE: src/lpfrc_parse.sv
// Frame parser state, running CRC and result formation for one byte per cycle while advance is high.
module lpfrc_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  lpfrc_pkg::item_t   item,
  output logic               res_valid,
  output lpfrc_pkg::result_t result
);
  import lpfrc_pkg::*;

  logic [POS_W-1:0]  pos, pos_next;
  logic [BYTE_W-1:0] held_type, held_type_next;
  logic [BYTE_W-1:0] held_address, held_address_next;
  logic [BYTE_W-1:0] held_length, held_length_next;
  logic [CRC_W-1:0]  crc_acc, crc_acc_next;
  logic [CRC_W-1:0]  crc_run, crc_run_next;
  logic [POS_W-1:0]  data_end;
  logic [POS_W-1:0]  crc_end;
  logic [POS_W-1:0]  data_off;
  logic [CRC_W-1:0]  crc_full;
  logic [CRC_W-1:0]  crc_fed;

  assign data_end = {1'b0, held_length} + POS_DATA;
  assign crc_end  = data_end + POS_W'(1);
  assign data_off = pos - POS_DATA;
  assign crc_full = {crc_acc[CRC_W-1:BYTE_W], item.value};
  assign crc_fed  = crc_feed(crc_run, item.value);

  always_comb begin
    pos_next          = pos;
    held_type_next    = held_type;
    held_address_next = held_address;
    held_length_next  = held_length;
    crc_acc_next      = crc_acc;
    crc_run_next      = crc_run;
    res_valid         = 1'b0;
    result.result_kind   = RES_DATA;
    result.data_byte     = '0;
    result.data_index    = '0;
    result.frame_type    = held_type;
    result.frame_address = held_address;
    result.frame_length  = held_length;
    result.received_crc  = '0;
    result.crc_ok        = 1'b0;
    if (item.kind == KIND_START) begin
      held_type_next    = item.value;
      held_address_next = '0;
      held_length_next  = '0;
      crc_acc_next      = '0;
      crc_run_next      = crc_feed(CRC_INIT, item.value);
      pos_next          = POS_ADDR;
    end else if (pos == POS_IDLE) begin
      pos_next = POS_IDLE;
    end else if (pos == POS_ADDR) begin
      held_address_next = item.value;
      crc_run_next      = crc_fed;
      pos_next          = POS_LEN;
    end else if (pos == POS_LEN) begin
      held_length_next = item.value;
      crc_run_next     = crc_fed;
      pos_next         = POS_DATA;
    end else if (pos < data_end) begin
      crc_run_next      = crc_fed;
      pos_next          = pos + POS_W'(1);
      res_valid         = 1'b1;
      result.data_byte  = item.value;
      result.data_index = data_off[BYTE_W-1:0];
    end else if (pos == data_end) begin
      crc_acc_next = {item.value, 8'h00};
      pos_next     = pos + POS_W'(1);
    end else if (pos == crc_end) begin
      crc_acc_next        = crc_full;
      pos_next            = POS_IDLE;
      res_valid           = 1'b1;
      result.result_kind  = RES_SUMMARY;
      result.received_crc = crc_full;
      result.crc_ok       = (crc_run == crc_full);
    end else begin
      pos_next = POS_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_IDLE;
      held_type    <= '0;
      held_address <= '0;
      held_length  <= '0;
      crc_acc      <= '0;
      crc_run      <= CRC_INIT;
    end else if (advance) begin
      pos          <= pos_next;
      held_type    <= held_type_next;
      held_address <= held_address_next;
      held_length  <= held_length_next;
      crc_acc      <= crc_acc_next;
      crc_run      <= crc_run_next;
    end
  end

endmodule

FILE: src/lpfrc_out_stage.sv
// Result register stage toward the master side.
module lpfrc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  lpfrc_pkg::result_t res_in,
  input  logic               m_ready,
  output logic               m_valid,
  output lpfrc_pkg::result_t res_out
);
  import lpfrc_pkg::*;

  logic valid_next;

  assign valid_next = load || (m_valid && !m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

FILE: src/length_prefixed_frame_receiver_crc.sv
// Top level of the length-prefixed frame receiver with CRC-16/XMODEM check.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   byte_value                              kind
//   m_axis    out  data_byte .. crc_ok (57 bits, padded)   result_kind
//
// One byte request is taken per cycle unless the master stalls; an accepted byte
// moves from the input register through the parser into the result register.
// The CRC update and position compare sit in the single parser stage.
// rst is synchronous and clears both stage valid flags and all frame state.
// A stalled master holds the result; the input register keeps taking requests
// until it is full too.
module length_prefixed_frame_receiver_crc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lpfrc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] byte_value
  input  logic                                s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] data_byte, [15:8] data_index, [23:16] frame_type, [31:24] frame_address,
  // [39:32] frame_length, [55:40] received_crc, [56] crc_ok, [63:57] zero
  output logic [lpfrc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tuser   // result_kind
);
  import lpfrc_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t res_q;

  assign s_item.kind  = s_axis_tuser;
  assign s_item.value = s_axis_tdata[BYTE_W-1:0];
  assign advance      = item_valid && (!m_axis_tvalid || m_axis_tready);

  lpfrc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .advance (advance),
    .valid   (item_valid),
    .item    (item)
  );

  lpfrc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .result    (res)
  );

  lpfrc_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && res_valid),
    .res_in  (res),
    .m_ready (m_axis_tready),
    .m_valid (m_axis_tvalid),
    .res_out (res_q)
  );

  assign m_axis_tuser = res_q.result_kind;
  assign m_axis_tdata = {7'b0, res_q.crc_ok, res_q.received_crc, res_q.frame_length,
                         res_q.frame_address, res_q.frame_type, res_q.data_index,
                         res_q.data_byte};

endmodule

FILE: src/lpfrc_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
module lpfrc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lpfrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                              m_axis_tuser
);
  import lpfrc_pkg::*;

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  a_summary_no_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == RES_SUMMARY) |-> m_axis_tdata[15:0] == 16'h0)
    else $error("summary carries data byte or index");

  a_data_no_crc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == RES_DATA) |-> m_axis_tdata[56:40] == 17'h0)
    else $error("data result carries crc fields");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:57] == 7'h0)
    else $error("tdata padding not zero");

endmodule

bind length_prefixed_frame_receiver_crc lpfrc_checker u_lpfrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
